[sv/i2crs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_pkg
// Shared types and constants of the bus report sniffer.
// ----------------------------------------------------------------------------
package i2crs_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MERGE,
    ST_WALK,
    ST_DECIDE,
    ST_SPLIT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  // Line sample codes, clock line in bit 1
  localparam logic [1:0] LINES_LOW_LOW   = 2'd0;
  localparam logic [1:0] LINES_LOW_HIGH  = 2'd1;
  localparam logic [1:0] LINES_HIGH_LOW  = 2'd2;
  localparam logic [1:0] LINES_HIGH_HIGH = 2'd3;

  localparam logic [6:0] DEV_ADDR_RESET = 7'h52;

  // Command bytes
  localparam logic [7:0] CMD_POLL      = 8'h00;
  localparam logic [7:0] CMD_UNLOCK_A  = 8'hF0;
  localparam logic [7:0] CMD_UNLOCK_B  = 8'h55;
  localparam logic [7:0] CMD_IDENT     = 8'hFA;
  localparam logic [7:0] CMD_KEY_A     = 8'h20;
  localparam logic [7:0] CMD_KEY_B     = 8'h30;
  localparam logic [7:0] CMD_BLOCK_LO  = 8'h40;
  localparam logic [7:0] CMD_BLOCK_HI  = 8'h46;
  localparam logic [7:0] CMD_BLOCK_KEY = 8'h4C;

  // Frame layout; entries 0 and 1 sit in registers, the rest in memory
  localparam int unsigned FRAME_LEN_LONG  = 51;
  localparam int unsigned FRAME_LEN_SHORT = 47;
  localparam int unsigned FMEM_DEPTH      = 49;
  localparam logic [7:0]  FRAME_TYPE_EXT  = 8'd3;
  localparam logic [5:0]  FADDR_LO        = 6'd0;   // frame entry 2
  localparam logic [5:0]  FADDR_HI        = 6'd12;  // frame entry 14
  localparam logic [5:0]  FADDR_KEY       = 6'd24;  // frame entry 26
  localparam logic [5:0]  FADDR_POLL      = 6'd32;  // frame entry 34

  // Frame memory access
  typedef struct packed {
    logic       we;
    logic [5:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [5:0] raddr;
  } fmem_ctl_t;

endpackage

[sv/i2crs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crs_if
// Valid/ready channels of the sniffer: line samples, report words, config.
// ----------------------------------------------------------------------------
interface i2crs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] bus_lines;
  modport source (output valid, output bus_lines, input ready);
  modport sink   (input valid, input bus_lines, output ready);
endinterface

interface i2crs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;
  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface i2crs_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] device_address;
  modport source (output valid, output device_address, input ready);
  modport sink   (input valid, input device_address, output ready);
endinterface
`default_nettype wire

[sv/i2crs_frame_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crs_frame_store
// Report frame memory (entries 2..50) with per-entry valid bits so that
// unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module i2crs_frame_store (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire i2crs_pkg::fmem_ctl_t ctl_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem [i2crs_pkg::FMEM_DEPTH];
  logic [i2crs_pkg::FMEM_DEPTH-1:0] valid_q;
  logic [7:0] rd_q;
  logic       rv_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[ctl_i.waddr] <= ctl_i.wdata;
    end
    if (ctl_i.re) begin
      rd_q <= mem[ctl_i.raddr];
    end
  end

  // Track written entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rv_q    <= 1'b0;
    end else begin
      if (ctl_i.we) begin
        valid_q[ctl_i.waddr] <= 1'b1;
      end
      if (ctl_i.re) begin
        rv_q <= valid_q[ctl_i.raddr];
      end
    end
  end

  assign rdata_o = rv_q ? rd_q : 8'd0;

endmodule
`default_nettype wire

[sv/i2c_controller_report_sniffer_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_controller_report_sniffer_top
// Passive bus watcher that rebuilds and sends the controller report frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan_i carries one sample of the bus lines per word. A sample that is
//   no clocked bit and no stop is taken with the port left ready. For a
//   clocked bit the byte word is read from the byte memory, merged and
//   written back, and the port is held off meanwhile.
//   A stop walks the byte memory, one byte per cycle through its single read
//   port; report fields may then be rewritten as nibble entries of the frame
//   memory (up to 16 entries).
//   An accepted poll sends 47 or 51 words on out_chan_o, each fetched (from the
//   frame memory past entry 1) and then loaded; frame_last marks the final word.
//   The output word sits in a register: a stalled receiver holds the
//   sequencer, and samples are taken again once the last word is loaded.
//   cfg_chan_i writes the device address at any time; it is always ready.
//   Reset clears line history, flags, key data and the frame (valid bits);
//   the block takes samples from the first cycle after reset.
// ----------------------------------------------------------------------------
module i2c_controller_report_sniffer_top #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  i2crs_in_if.sink   in_chan_i,
  i2crs_out_if.source out_chan_o,
  i2crs_cfg_if.sink  cfg_chan_i
);

  localparam int unsigned AW = $clog2(MAX_BYTES);
  localparam int unsigned KW = $clog2(MAX_BYTES + 1);

  i2crs_pkg::state_e state_q, state_d;

  logic [6:0]    dev_addr_q;
  logic [1:0]    prev_q, prev_d;
  logic [KW-1:0] k_q, k_d;
  logic [3:0]    slot_q, slot_d;
  logic          bit_q, bit_d;
  logic          poll_q, poll_d, ident_q, ident_d, keycap_q, keycap_d;
  logic [7:0]    key_cnt_q, key_cnt_d;
  logic [7:0]    snap_q [8];
  logic [7:0]    snap_d [8];
  logic [7:0]    frame0_q, frame0_d, frame1_q, frame1_d;
  logic [7:0]    cap_q [9];
  logic [7:0]    cap_d [9];
  logic [KW-1:0] n_q, n_d, wk_q, wk_d, rd_idx_q, rd_idx_d;
  logic          rd_vld_q, rd_vld_d;
  logic          ack0_q, ack0_d, ack_fail_q, ack_fail_d;
  logic [5:0]    sp_dst_q, sp_dst_d;
  logic [3:0]    sp_src_q, sp_src_d;
  logic [5:0]    sp_end_q, sp_end_d;
  logic [5:0]    e_q, e_d;
  logic          emit_q, emit_d;
  logic          ov_q, ov_d, olast_q, olast_d;
  logic [7:0]    ob_q, ob_d;

  // Byte memory: {ack, data}
  logic [8:0]    bmem [MAX_BYTES];
  logic [8:0]    brd_q;
  logic          bre, bwe;
  logic [AW-1:0] braddr;
  logic [8:0]    bwdata;

  i2crs_pkg::fmem_ctl_t fctl;
  logic [7:0]    frd;

  // Sample decode
  logic       in_acc;
  logic [1:0] cur;
  logic       ev_start, ev_stop, ev_one, ev_zero, full;
  assign in_chan_i.ready = (state_q == i2crs_pkg::ST_IDLE);
  assign in_acc   = in_chan_i.valid && in_chan_i.ready;
  assign cur      = in_chan_i.bus_lines;
  assign ev_start = (prev_q == i2crs_pkg::LINES_HIGH_HIGH) && (cur == i2crs_pkg::LINES_HIGH_LOW);
  assign ev_stop  = (prev_q == i2crs_pkg::LINES_HIGH_LOW) && (cur == i2crs_pkg::LINES_HIGH_HIGH);
  assign ev_one   = (prev_q == i2crs_pkg::LINES_LOW_HIGH) && (cur == i2crs_pkg::LINES_HIGH_HIGH);
  assign ev_zero  = (prev_q == i2crs_pkg::LINES_LOW_LOW) && (cur == i2crs_pkg::LINES_HIGH_LOW);
  assign full     = (k_q == KW'(MAX_BYTES));

  assign cfg_chan_i.ready = 1'b1;

  // Transaction checks for the decision cycle
  logic       addr_ok, is_wr, zeros8, match8, emit_ok;
  logic [7:0] id_x, id_y, key_next;
  logic [5:0] frame_len;
  always_comb begin
    addr_ok = (cap_q[0][7:1] == dev_addr_q);
    is_wr   = !cap_q[0][0];
    zeros8  = 1'b1;
    match8  = 1'b1;
    for (int i = 1; i < 9; i++) begin
      if (cap_q[i] != 8'd0) zeros8 = 1'b0;
      if (cap_q[i] != snap_q[i-1]) match8 = 1'b0;
    end
    id_x = (n_q == KW'(7)) ? cap_q[5] : cap_q[7];
    id_y = (n_q == KW'(7)) ? cap_q[6] : cap_q[8];
    key_next = (key_cnt_q == 8'd254) ? 8'd0 : key_cnt_q + 8'd1;
    if (key_next == 8'd10) key_next = 8'd11;
    emit_ok = !((n_q == KW'(9)) && (zeros8 || match8));
    frame_len = (frame0_q == i2crs_pkg::FRAME_TYPE_EXT) ?
                6'(i2crs_pkg::FRAME_LEN_LONG) : 6'(i2crs_pkg::FRAME_LEN_SHORT);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2crs_pkg::ST_IDLE: begin
        if (in_acc && ev_stop) state_d = i2crs_pkg::ST_WALK;
        else if (in_acc && (ev_one || ev_zero) && !full) state_d = i2crs_pkg::ST_MERGE;
      end
      i2crs_pkg::ST_MERGE: state_d = i2crs_pkg::ST_IDLE;
      i2crs_pkg::ST_WALK: begin
        if (wk_q == n_q && !rd_vld_q) state_d = i2crs_pkg::ST_DECIDE;
      end
      i2crs_pkg::ST_DECIDE: begin
        state_d = (sp_end_d != 6'd0) ? i2crs_pkg::ST_SPLIT : i2crs_pkg::ST_IDLE;
      end
      i2crs_pkg::ST_SPLIT: begin
        if (sp_end_q == 6'd0) state_d = i2crs_pkg::ST_IDLE;
        else if (e_q == sp_end_q) begin
          state_d = emit_q ? i2crs_pkg::ST_EMIT_RD : i2crs_pkg::ST_IDLE;
        end
      end
      i2crs_pkg::ST_EMIT_RD: state_d = i2crs_pkg::ST_EMIT_LD;
      i2crs_pkg::ST_EMIT_LD: begin
        if (!ov_q || out_chan_o.ready) begin
          state_d = (e_q == frame_len - 6'd1) ? i2crs_pkg::ST_IDLE : i2crs_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = i2crs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    logic [7:0] sbyte;
    logic [3:0] sidx;
    prev_d = prev_q;  k_d = k_q;  slot_d = slot_q;  bit_d = bit_q;
    poll_d = poll_q;  ident_d = ident_q;  keycap_d = keycap_q;
    key_cnt_d = key_cnt_q;  frame0_d = frame0_q;  frame1_d = frame1_q;
    snap_d = snap_q;  cap_d = cap_q;
    n_d = n_q;  wk_d = wk_q;  rd_idx_d = rd_idx_q;  rd_vld_d = 1'b0;
    ack0_d = ack0_q;  ack_fail_d = ack_fail_q;
    sp_dst_d = sp_dst_q;  sp_src_d = sp_src_q;  sp_end_d = sp_end_q;
    e_d = e_q;  emit_d = emit_q;
    ov_d = ov_q && !out_chan_o.ready;  olast_d = olast_q;  ob_d = ob_q;
    bre = 1'b0;  bwe = 1'b0;  braddr = k_q[AW-1:0];  bwdata = brd_q;
    fctl = '0;
    sidx = 4'd0;  sbyte = 8'd0;
    case (state_q)
      // Decode a sample; start a merge or a walk
      i2crs_pkg::ST_IDLE: begin
        if (in_acc) begin
          prev_d = cur;
          bit_d  = ev_one;
          if (ev_start) begin
            k_d = '0;
            slot_d = 4'd0;
          end else if (ev_stop) begin
            slot_d = 4'd0;
            n_d = (k_q == '0) ? KW'(1) : k_q;
            wk_d = '0;
            ack_fail_d = 1'b0;
          end else if ((ev_one || ev_zero) && !full) begin
            bre = 1'b1;
          end
        end
      end
      // Merge the bit into the byte word and write it back
      i2crs_pkg::ST_MERGE: begin
        bwe = 1'b1;
        if (slot_q == 4'd8) begin
          bwdata[8] = bit_q;
          slot_d = 4'd0;
          k_d = k_q + KW'(1);
        end else begin
          bwdata[3'd7 - slot_q[2:0]] = bit_q;
          slot_d = slot_q + 4'd1;
        end
      end
      // Read all stored bytes; capture the head, check ACKs
      i2crs_pkg::ST_WALK: begin
        if (wk_q != n_q) begin
          bre = 1'b1;
          braddr = wk_q[AW-1:0];
          rd_vld_d = 1'b1;
          rd_idx_d = wk_q;
          wk_d = wk_q + KW'(1);
        end
        if (rd_vld_q) begin
          if (rd_idx_q < KW'(9)) cap_d[rd_idx_q[3:0]] = brd_q[7:0];
          if (rd_idx_q == '0) begin
            ack0_d = brd_q[8];
          end else if (cap_q[0][0] && rd_idx_q == n_q - KW'(1)) begin
            if (!brd_q[8]) ack_fail_d = 1'b1;
          end else if (brd_q[8]) begin
            ack_fail_d = 1'b1;
          end
        end
      end
      // Act on the finished transaction
      i2crs_pkg::ST_DECIDE: begin
        emit_d = 1'b0;
        sp_end_d = 6'd0;
        e_d = 6'd0;
        if (addr_ok) begin
          ident_d = 1'b0;
          poll_d = 1'b0;
          if (!ack0_q && !ack_fail_q) begin
            if (is_wr) begin
              if (n_q == KW'(2) && cap_q[1] == i2crs_pkg::CMD_POLL) begin
                poll_d = 1'b1;
              end else if (n_q == KW'(3) && cap_q[1] == i2crs_pkg::CMD_UNLOCK_A &&
                           cap_q[2] == i2crs_pkg::CMD_UNLOCK_B) begin
                frame1_d = 8'd255;
              end else if (n_q == KW'(2) && cap_q[1] == i2crs_pkg::CMD_IDENT) begin
                ident_d = 1'b1;
              end else if (n_q == KW'(2) && (cap_q[1] == i2crs_pkg::CMD_KEY_A ||
                                             cap_q[1] == i2crs_pkg::CMD_KEY_B)) begin
                keycap_d = 1'b1;
              end else if (n_q == KW'(8) && cap_q[1] == i2crs_pkg::CMD_BLOCK_LO) begin
                sp_dst_d = i2crs_pkg::FADDR_LO;  sp_src_d = 4'd2;  sp_end_d = 6'd12;
              end else if (n_q == KW'(8) && cap_q[1] == i2crs_pkg::CMD_BLOCK_HI) begin
                sp_dst_d = i2crs_pkg::FADDR_HI;  sp_src_d = 4'd2;  sp_end_d = 6'd12;
              end else if (n_q == KW'(6) && cap_q[1] == i2crs_pkg::CMD_BLOCK_KEY) begin
                sp_dst_d = i2crs_pkg::FADDR_KEY;  sp_src_d = 4'd2;  sp_end_d = 6'd8;
                key_cnt_d = key_next;
                frame1_d = key_next;
              end
            end else if (keycap_q && n_q == KW'(9)) begin
              snap_d[7] = cap_q[1];
              for (int i = 0; i < 7; i++) snap_d[i] = cap_q[i+2];
              keycap_d = 1'b0;
            end else if (ident_q && (n_q == KW'(7) || n_q == KW'(9))) begin
              if (id_x == 8'd0 && id_y == 8'd0) frame0_d = 8'd0;
              else if (id_x == 8'd1 && id_y == 8'd1) frame0_d = 8'd1;
              else frame0_d = 8'd2;
            end else if (poll_q && n_q >= KW'(7) && emit_ok) begin
              emit_d = 1'b1;
              sp_dst_d = i2crs_pkg::FADDR_POLL;
              if (n_q == KW'(11)) begin
                frame0_d = i2crs_pkg::FRAME_TYPE_EXT;
                sp_src_d = 4'd1;  sp_end_d = 6'd16;
              end else begin
                sp_src_d = (n_q == KW'(22)) ? 4'd3 : 4'd1;
                sp_end_d = 6'd12;
              end
            end
          end
        end
      end
      // Write nibble entries, one per cycle
      i2crs_pkg::ST_SPLIT: begin
        if (e_q != sp_end_q) begin
          sidx = sp_src_q + {1'b0, e_q[3:1]};
          sbyte = cap_q[sidx];
          fctl.we = 1'b1;
          fctl.waddr = sp_dst_q + e_q;
          fctl.wdata = e_q[0] ? {sbyte[3:0], 4'd0} : {sbyte[7:4], 4'd0};
          e_d = e_q + 6'd1;
        end else begin
          e_d = 6'd0;
        end
      end
      // Fetch the next frame entry
      i2crs_pkg::ST_EMIT_RD: begin
        fctl.re = (e_q >= 6'd2);
        fctl.raddr = e_q - 6'd2;
      end
      // Load the output word when free
      i2crs_pkg::ST_EMIT_LD: begin
        if (!ov_q || out_chan_o.ready) begin
          ov_d = 1'b1;
          ob_d = (e_q == 6'd0) ? frame0_q : ((e_q == 6'd1) ? frame1_q : frd);
          olast_d = (e_q == frame_len - 6'd1);
          e_d = e_q + 6'd1;
        end
      end
      default: ;
    endcase
  end

  // Byte memory
  always_ff @(posedge clk_i) begin
    if (bwe) bmem[k_q[AW-1:0]] <= bwdata;
    if (bre) brd_q <= bmem[braddr];
  end

  i2crs_frame_store u_frame_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (fctl),
    .rdata_o (frd)
  );

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= i2crs_pkg::ST_IDLE;
      dev_addr_q <= i2crs_pkg::DEV_ADDR_RESET;
      prev_q     <= i2crs_pkg::LINES_HIGH_HIGH;
      k_q        <= '0;
      slot_q     <= 4'd0;
      poll_q     <= 1'b0;
      ident_q    <= 1'b0;
      keycap_q   <= 1'b0;
      key_cnt_q  <= 8'd0;
      frame0_q   <= 8'd0;
      frame1_q   <= 8'd0;
      for (int i = 0; i < 8; i++) snap_q[i] <= 8'd0;
      rd_vld_q   <= 1'b0;
      wk_q       <= '0;
      n_q        <= '0;
      e_q        <= 6'd0;
      emit_q     <= 1'b0;
      sp_end_q   <= 6'd0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_chan_i.valid) dev_addr_q <= cfg_chan_i.device_address;
      prev_q     <= prev_d;
      k_q        <= k_d;
      slot_q     <= slot_d;
      poll_q     <= poll_d;
      ident_q    <= ident_d;
      keycap_q   <= keycap_d;
      key_cnt_q  <= key_cnt_d;
      frame0_q   <= frame0_d;
      frame1_q   <= frame1_d;
      snap_q     <= snap_d;
      rd_vld_q   <= rd_vld_d;
      wk_q       <= wk_d;
      n_q        <= n_d;
      e_q        <= e_d;
      emit_q     <= emit_d;
      sp_end_q   <= sp_end_d;
      ov_q       <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bit_q      <= bit_d;
    cap_q      <= cap_d;
    rd_idx_q   <= rd_idx_d;
    ack0_q     <= ack0_d;
    ack_fail_q <= ack_fail_d;
    sp_dst_q   <= sp_dst_d;
    sp_src_q   <= sp_src_d;
    ob_q       <= ob_d;
    olast_q    <= olast_d;
  end

  assign out_chan_o.valid      = ov_q;
  assign out_chan_o.frame_byte = ob_q;
  assign out_chan_o.frame_last = olast_q;

endmodule
`default_nettype wire

[sv/i2crs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2crs_checker
// Port-level checks of the sniffer's report channel.
// ----------------------------------------------------------------------------
module i2crs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_last_i
);

  // Hold a stalled word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_last_i))
    else $error("stalled report word changed");

  // Drop valid after the final word of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> !out_valid_i)
    else $error("word follows frame end without a new poll");

  // Start out of reset with no word pending
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("report word present after reset");

endmodule

bind i2c_controller_report_sniffer_top i2crs_checker u_i2crs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_chan_o.valid),
  .out_ready_i (out_chan_o.ready),
  .out_byte_i  (out_chan_o.frame_byte),
  .out_last_i  (out_chan_o.frame_last)
);
`default_nettype wire

[tb/i2crs_report_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crs_report_checker
// Watches the sample, report and address channels of the sniffer, keeps its
// own copy of the bus decoder and report state, and compares every report
// word that leaves the block with the word predicted for it.
// ----------------------------------------------------------------------------
module i2crs_report_checker #(
  parameter int unsigned MAX_BYTES = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  i2crs_in_if  in_w,
  i2crs_out_if out_w,
  i2crs_cfg_if cfg_w,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned SLOT_CAP = MAX_BYTES * 9;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } report_word_t;

  logic [6:0]   watch_addr;
  logic [1:0]   last_lines;
  int unsigned  slot_pos;
  logic [7:0]   bus_bytes [MAX_BYTES];
  logic         bus_acks [MAX_BYTES];
  logic         poll_armed, ident_armed, key_armed;
  logic [7:0]   key_snap [8];
  logic [7:0]   key_count;
  logic [7:0]   frame [i2crs_pkg::FRAME_LEN_LONG];
  report_word_t report_words [$];

  // Store one clocked bit into its data or ACK slot
  function automatic void take_bit(logic v);
    int unsigned k, r;
    if (slot_pos >= SLOT_CAP) return;
    k = slot_pos / 9;
    r = slot_pos % 9;
    if (r == 8) bus_acks[k] = v;
    else bus_bytes[k][7 - r] = v;
    slot_pos++;
  endfunction

  // Spread stored bytes over frame entries, high nibble then low nibble
  function automatic void split_nibbles(int unsigned dst, int unsigned src, int unsigned cnt);
    for (int unsigned i = 0; i < cnt; i++) begin
      frame[dst + 2 * i]     = {bus_bytes[src + i][7:4], 4'h0};
      frame[dst + 2 * i + 1] = {bus_bytes[src + i][3:0], 4'h0};
    end
  endfunction

  function automatic void queue_frame();
    int unsigned len;
    report_word_t w;
    len = (frame[0] == i2crs_pkg::FRAME_TYPE_EXT) ? i2crs_pkg::FRAME_LEN_LONG :
                                                    i2crs_pkg::FRAME_LEN_SHORT;
    for (int unsigned k = 0; k < len; k++) begin
      w.data = frame[k];
      w.last = (k == len - 1);
      report_words.push_back(w);
    end
  endfunction

  // Check the finished transaction and apply its effect
  function automatic void close_transaction();
    int unsigned n, zeros, match;
    logic was_ident, was_poll, is_write;
    logic [7:0] x, y;
    slot_pos = slot_pos - slot_pos % 9;
    n = slot_pos / 9;
    if (n == 0) n = 1;
    if (bus_bytes[0][7:1] != watch_addr) return;
    was_ident   = ident_armed;
    was_poll    = poll_armed;
    ident_armed = 1'b0;
    poll_armed  = 1'b0;
    if (bus_acks[0]) return;
    is_write = !bus_bytes[0][0];
    for (int unsigned k = 1; k < n; k++) begin
      if (!is_write && k == n - 1) begin
        if (!bus_acks[k]) return;
      end else if (bus_acks[k]) begin
        return;
      end
    end
    if (is_write) begin
      if (n == 2 && bus_bytes[1] == i2crs_pkg::CMD_POLL) begin
        poll_armed = 1'b1;
      end else if (n == 3 && bus_bytes[1] == i2crs_pkg::CMD_UNLOCK_A &&
                   bus_bytes[2] == i2crs_pkg::CMD_UNLOCK_B) begin
        frame[1] = 8'd255;
      end else if (n == 2 && bus_bytes[1] == i2crs_pkg::CMD_IDENT) begin
        ident_armed = 1'b1;
      end else if (n == 2 && (bus_bytes[1] == i2crs_pkg::CMD_KEY_A ||
                              bus_bytes[1] == i2crs_pkg::CMD_KEY_B)) begin
        key_armed = 1'b1;
      end else if (n == 8 && bus_bytes[1] == i2crs_pkg::CMD_BLOCK_LO) begin
        split_nibbles(2, 2, 6);
      end else if (n == 8 && bus_bytes[1] == i2crs_pkg::CMD_BLOCK_HI) begin
        split_nibbles(14, 2, 6);
      end else if (n == 6 && bus_bytes[1] == i2crs_pkg::CMD_BLOCK_KEY) begin
        split_nibbles(26, 2, 4);
        // count modulo 255, skipping ten
        key_count = (key_count == 8'd254) ? 8'd0 : key_count + 8'd1;
        if (key_count == 8'd10) key_count = 8'd11;
        frame[1] = key_count;
      end
      return;
    end
    if (key_armed && n == 9) begin
      key_snap[7] = bus_bytes[1];
      for (int unsigned k = 0; k < 7; k++) key_snap[k] = bus_bytes[k + 2];
      key_armed = 1'b0;
    end else if (was_ident && (n == 7 || n == 9)) begin
      x = bus_bytes[n - 2];
      y = bus_bytes[n - 1];
      if (x == 8'd0 && y == 8'd0) frame[0] = 8'd0;
      else if (x == 8'd1 && y == 8'd1) frame[0] = 8'd1;
      else frame[0] = 8'd2;
    end else if (was_poll && n >= 7) begin
      if (n == 9) begin
        zeros = 0;
        match = 0;
        for (int unsigned k = 1; k < 9; k++) begin
          if (bus_bytes[k] == key_snap[k - 1]) match++;
          if (bus_bytes[k] == 8'd0) zeros++;
        end
        // blank or key-echo polls send nothing
        if (zeros == 8 || match == 8) return;
      end
      if (n == 11) begin
        frame[0] = i2crs_pkg::FRAME_TYPE_EXT;
        split_nibbles(34, 1, 8);
      end else begin
        split_nibbles(34, (n == 22) ? 3 : 1, 6);
      end
      queue_frame();
    end
  endfunction

  // Decode one line sample against the previous one
  function automatic void step_lines(logic [1:0] cur);
    logic [1:0] prev;
    prev = last_lines;
    last_lines = cur;
    if (prev == cur) return;
    if (prev == i2crs_pkg::LINES_HIGH_HIGH && cur == i2crs_pkg::LINES_HIGH_LOW) begin
      slot_pos = 0;
    end else if (prev == i2crs_pkg::LINES_HIGH_LOW && cur == i2crs_pkg::LINES_HIGH_HIGH) begin
      close_transaction();
    end else if (prev == i2crs_pkg::LINES_LOW_HIGH && cur == i2crs_pkg::LINES_HIGH_HIGH) begin
      take_bit(1'b1);
    end else if (prev == i2crs_pkg::LINES_LOW_LOW && cur == i2crs_pkg::LINES_HIGH_LOW) begin
      take_bit(1'b0);
    end
  endfunction

  function automatic void note_fail(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%0t: mismatch: %s", $realtime, msg);
  endfunction

  // Predict on accepted samples, compare accepted report words
  always @(posedge clk_i or negedge rst_ni) begin
    report_word_t exp_w;
    if (!rst_ni) begin
      watch_addr   = i2crs_pkg::DEV_ADDR_RESET;
      last_lines   = i2crs_pkg::LINES_HIGH_HIGH;
      slot_pos     = 0;
      poll_armed   = 1'b0;
      ident_armed  = 1'b0;
      key_armed    = 1'b0;
      key_count    = 8'd0;
      fail_count_o = 0;
      for (int i = 0; i < 8; i++) key_snap[i] = 8'd0;
      for (int i = 0; i < i2crs_pkg::FRAME_LEN_LONG; i++) frame[i] = 8'd0;
      report_words.delete();
    end else begin
      if (cfg_w.valid && cfg_w.ready) watch_addr = cfg_w.device_address;
      if (out_w.valid && out_w.ready) begin
        if (report_words.size() == 0) begin
          note_fail($sformatf("unexpected word %02h last %0b", out_w.frame_byte,
                              out_w.frame_last));
        end else begin
          exp_w = report_words.pop_front();
          if (exp_w.data !== out_w.frame_byte || exp_w.last !== out_w.frame_last)
            note_fail($sformatf("word exp %02h last %0b, got %02h last %0b", exp_w.data,
                                exp_w.last, out_w.frame_byte, out_w.frame_last));
        end
      end
      if (in_w.valid && in_w.ready) step_lines(in_w.bus_lines);
    end
    pending_o = report_words.size();
  end

endmodule

[tb/tb_i2c_controller_report_sniffer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_controller_report_sniffer_top
// Drives bus line samples into the sniffer as whole bus transactions (polls,
// ident and key exchanges, block writes, faulty and noisy traffic), with
// random sender gaps and receiver stalls, across several device addresses.
// A checker beside the block predicts and compares the report words.
// ----------------------------------------------------------------------------
module tb_i2c_controller_report_sniffer_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending_words;
  int   gap_pct, stall_pct, quiet_cycles;
  logic [1:0] cur_lines;
  logic [6:0] bus_addr;
  logic [7:0] tx_bytes [$];
  logic       tx_acks [$];

  i2crs_in_if  in_chan ();
  i2crs_out_if out_chan ();
  i2crs_cfg_if cfg_chan ();

  i2c_controller_report_sniffer_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_chan),
    .out_chan_o (out_chan),
    .cfg_chan_i (cfg_chan)
  );

  i2crs_report_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_w         (in_chan),
    .out_w        (out_chan),
    .cfg_w        (cfg_chan),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  always #4 clk_i = ~clk_i;

  // Stall the receiver at random
  always @(negedge clk_i) begin
    out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        (cfg_chan.valid && cfg_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
        $display("FAIL i2c_controller_report_sniffer_top");
        $finish;
      end
    end
  end

  // Offer one line sample, with random gaps ahead of it
  task automatic put(input logic [1:0] v);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_chan.valid     <= 1'b1;
    in_chan.bus_lines <= v;
    cur_lines = v;
    do @(posedge clk_i); while (!in_chan.ready);
    @(negedge clk_i);
  endtask

  task automatic send_bit(input logic b);
    if (cur_lines[1]) put({1'b0, cur_lines[0]});
    put({1'b0, b});
    put({1'b1, b});
  endtask

  task automatic send_start();
    if (cur_lines == i2crs_pkg::LINES_HIGH_LOW) put(i2crs_pkg::LINES_LOW_LOW);
    if (cur_lines == i2crs_pkg::LINES_LOW_LOW) put(i2crs_pkg::LINES_LOW_HIGH);
    if (cur_lines == i2crs_pkg::LINES_LOW_HIGH) put(i2crs_pkg::LINES_HIGH_HIGH);
    put(i2crs_pkg::LINES_HIGH_LOW);
  endtask

  // Clock high with data low, then release data
  task automatic send_stop();
    if (cur_lines[1]) put({1'b0, cur_lines[0]});
    put(i2crs_pkg::LINES_LOW_LOW);
    put(i2crs_pkg::LINES_HIGH_LOW);
    put(i2crs_pkg::LINES_HIGH_HIGH);
  endtask

  function automatic void open_tx(input logic [6:0] a, input logic rd);
    tx_bytes.delete();
    tx_acks.delete();
    tx_bytes.push_back({a, rd});
    tx_acks.push_back(1'b0);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    tx_acks.push_back(1'b0);
  endfunction

  // Play the built transaction, dropping the final cut bits
  task automatic play_tx(input int cut);
    int total, sent;
    total = tx_bytes.size() * 9 - cut;
    sent = 0;
    send_start();
    foreach (tx_bytes[i]) begin
      for (int j = 7; j >= -1; j--) begin
        if (sent < total) send_bit(j >= 0 ? tx_bytes[i][j] : tx_acks[i]);
        sent++;
      end
    end
    send_stop();
  endtask

  task automatic write_cmd(input logic [7:0] cmd);
    open_tx(bus_addr, 1'b0);
    add_byte(cmd);
    play_tx(0);
  endtask

  // Read of n bytes, the last one NACKed; random data unless blank
  task automatic read_n(input int n, input logic blank);
    open_tx(bus_addr, 1'b1);
    for (int i = 1; i < n; i++) add_byte(blank ? 8'h00 : 8'($urandom));
    tx_acks[n - 1] = 1'b1;
  endtask

  task automatic block_write(input logic [7:0] cmd, input int n, input logic [7:0] fill);
    open_tx(bus_addr, 1'b0);
    add_byte(cmd);
    for (int i = 2; i < n; i++) add_byte(fill);
    play_tx(0);
  endtask

  task automatic ident_read(input int n, input int tail);
    write_cmd(i2crs_pkg::CMD_IDENT);
    read_n(n, 1'b0);
    if (tail < 2) begin
      tx_bytes[n - 2] = 8'(tail);
      tx_bytes[n - 1] = 8'(tail);
    end
    play_tx(0);
  endtask

  task automatic set_address(input logic [6:0] a);
    cfg_chan.valid          <= 1'b1;
    cfg_chan.device_address <= a;
    do @(posedge clk_i); while (!cfg_chan.ready);
    @(negedge clk_i);
    cfg_chan.valid <= 1'b0;
    bus_addr = a;
  endtask

  // Hold off the sender until every report word is out, then let the block settle
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_words != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic directed_run();
    logic [7:0] key_bytes [$];
    // unlock, then all three ident outcomes
    open_tx(bus_addr, 1'b0);
    add_byte(i2crs_pkg::CMD_UNLOCK_A);
    add_byte(i2crs_pkg::CMD_UNLOCK_B);
    play_tx(0);
    ident_read(7, 0);
    ident_read(9, 1);
    ident_read(9, 2);
    // polls of the short and long layouts and the offset layout
    write_cmd(i2crs_pkg::CMD_POLL); read_n(7, 1'b0); play_tx(0);
    write_cmd(i2crs_pkg::CMD_POLL); read_n(22, 1'b0); play_tx(0);
    block_write(i2crs_pkg::CMD_BLOCK_LO, 8, 8'hFF);
    block_write(i2crs_pkg::CMD_BLOCK_HI, 8, 8'h00);
    block_write(i2crs_pkg::CMD_BLOCK_KEY, 6, 8'hA5);
    write_cmd(i2crs_pkg::CMD_POLL); read_n(11, 1'b0); play_tx(0);
    // capture a key, then a poll echoing it and a blank poll: both silent
    write_cmd(i2crs_pkg::CMD_KEY_A);
    read_n(9, 1'b0);
    play_tx(0);
    key_bytes = tx_bytes;
    write_cmd(i2crs_pkg::CMD_POLL);
    read_n(9, 1'b0);
    for (int k = 1; k < 8; k++) tx_bytes[k] = key_bytes[k + 1];
    tx_bytes[8] = key_bytes[1];
    play_tx(0);
    write_cmd(i2crs_pkg::CMD_POLL); read_n(9, 1'b1); play_tx(0);
    // faults: wrong address, ACKed read end, NACKed address, partial byte
    write_cmd(i2crs_pkg::CMD_POLL);
    read_n(7, 1'b0); tx_acks[6] = 1'b0; play_tx(0);
    write_cmd(i2crs_pkg::CMD_POLL);
    read_n(7, 1'b0); tx_bytes[0][7:1] = ~bus_addr; play_tx(0);
    read_n(7, 1'b0); tx_acks[0] = 1'b1; play_tx(0);
    write_cmd(i2crs_pkg::CMD_POLL); read_n(8, 1'b0); play_tx(5);
    // start straight into stop, and a write past capacity
    send_start();
    send_stop();
    block_write(i2crs_pkg::CMD_BLOCK_LO, 34, 8'h3C);
    // run the key counter through the skip at ten and the wrap
    for (int i = 0; i < 256; i++) block_write(i2crs_pkg::CMD_BLOCK_KEY, 6, 8'($urandom));
    write_cmd(i2crs_pkg::CMD_POLL); read_n(7, 1'b0); play_tx(0);
  endtask

  task automatic random_tx();
    int kind, n;
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1, 2, 9: begin
        write_cmd(($urandom_range(0, 7) == 0) ? i2crs_pkg::CMD_BLOCK_KEY :
                                                i2crs_pkg::CMD_POLL);
        case ($urandom_range(0, 6))
          0: n = 7;
          1: n = 9;
          2: n = 11;
          3: n = 22;
          default: n = $urandom_range(7, 12);
        endcase
        read_n(n, $urandom_range(0, 9) == 0);
        if (kind == 9) tx_acks[$urandom_range(0, n - 1)] ^= 1'b1;
        play_tx(($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0);
      end
      3: ident_read($urandom_range(0, 1) ? 7 : 9, $urandom_range(0, 2));
      4: begin
        write_cmd($urandom_range(0, 1) ? i2crs_pkg::CMD_KEY_A : i2crs_pkg::CMD_KEY_B);
        read_n(9, 1'b0);
        play_tx(0);
      end
      5: begin
        block_write($urandom_range(0, 1) ? i2crs_pkg::CMD_BLOCK_LO : i2crs_pkg::CMD_BLOCK_HI,
                    8, 8'($urandom));
      end
      6: block_write(i2crs_pkg::CMD_BLOCK_KEY, 6, 8'($urandom));
      7: begin
        open_tx(bus_addr, 1'b0);
        add_byte(i2crs_pkg::CMD_UNLOCK_A);
        add_byte(i2crs_pkg::CMD_UNLOCK_B);
        play_tx(0);
      end
      8: begin
        open_tx(bus_addr ^ 7'($urandom_range(1, 127)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < 6; i++) add_byte(8'($urandom));
        play_tx(0);
      end
      10: begin
        open_tx(bus_addr, 1'($urandom_range(0, 1)));
        n = $urandom_range(1, 34);
        for (int i = 1; i < n; i++) add_byte(8'($urandom));
        foreach (tx_acks[i]) tx_acks[i] = ($urandom_range(0, 5) == 0);
        play_tx(0);
      end
      default: begin
        n = $urandom_range(5, 20);
        repeat (n) put(2'($urandom));
      end
    endcase
  endtask

  initial begin
    in_chan.valid           <= 1'b0;
    in_chan.bus_lines       <= i2crs_pkg::LINES_HIGH_HIGH;
    cfg_chan.valid          <= 1'b0;
    cfg_chan.device_address <= i2crs_pkg::DEV_ADDR_RESET;
    cur_lines  = i2crs_pkg::LINES_HIGH_HIGH;
    bus_addr   = i2crs_pkg::DEV_ADDR_RESET;
    gap_pct    = 0;
    stall_pct  = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_run();
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_address(7'd0);
        1: set_address(7'd127);
        2: set_address(i2crs_pkg::DEV_ADDR_RESET);
        default: set_address(7'($urandom));
      endcase
      gap_pct   = (ph == 1 || ph == 3) ? ((ph == 3) ? 37 : 49) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 37 : 49) : 0;
      repeat (25) random_tx();
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS i2c_controller_report_sniffer_top");
    end else begin
      $display("FAIL i2c_controller_report_sniffer_top");
    end
    $finish;
  end

endmodule

[i2c_controller_report_sniffer_top.f]
sv/i2crs_pkg.sv
sv/i2crs_if.sv
sv/i2crs_frame_store.sv
sv/i2c_controller_report_sniffer_top.sv
sv/i2crs_checker.sv
tb/i2crs_report_checker.sv
tb/tb_i2c_controller_report_sniffer_top.sv
